// File: src/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher unit.
package rc4_pkg;

  typedef logic [7:0] byte_t;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef struct packed {
    logic  we;
    byte_t waddr;
    byte_t wdata;
    logic  re;
    byte_t raddr;
  } ram_req_t;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_INIT  = 12'b0000_0000_0010,
    ST_KS_RI = 12'b0000_0000_0100,
    ST_KS_RJ = 12'b0000_0000_1000,
    ST_KS_WI = 12'b0000_0001_0000,
    ST_KS_WJ = 12'b0000_0010_0000,
    ST_GS_RI = 12'b0000_0100_0000,
    ST_GS_RJ = 12'b0000_1000_0000,
    ST_GS_WI = 12'b0001_0000_0000,
    ST_GS_WJ = 12'b0010_0000_0000,
    ST_GS_RT = 12'b0100_0000_0000,
    ST_GS_OUT = 12'b1000_0000_0000
  } state_e;

endpackage

// File: src/rc4_ram.sv
// 256 by 8 bit memory with one write port and one registered read port.
module rc4_ram (
  input  logic              clk_i,
  input  rc4_pkg::ram_req_t req_i,
  output rc4_pkg::byte_t    rdata_o
);

  rc4_pkg::byte_t mem [256];
  rc4_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rc4_stream_cipher_unit.sv
// Top level of the RC4 stream cipher unit: sequencer, key count and result register.
// Key bytes are taken one per cycle while the output is free and kept in a
// key store; the byte marked as the last of its run starts the key schedule, which
// fills the S-box with the identity and then runs 256 swap steps, during which no
// transfer is accepted. Once keyed, each data byte goes through GS_RI to GS_OUT,
// where its result is loaded, before the next input can be taken; this is set by the
// single S-box memory, which serves one read and one write a cycle for the dependent
// reads and the swap. Data sent before any key passes straight through with no_key set,
// one byte a cycle while the output is free. Key bytes beyond KEY_MAX are dropped.
module rc4_stream_cipher_unit #(
  parameter int KEY_MAX = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [7:0]          byte_in_i,
  input  logic                last_of_run_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          byte_out_o,
  output logic [7:0]          keystream_byte_o,
  output logic                end_of_message_o,
  output logic                no_key_o
);

  localparam int KCW = $clog2(KEY_MAX + 1);

  rc4_pkg::state_e   state_q, state_d;
  rc4_pkg::byte_t    i_q, i_d, j_q, j_d, kidx_q, kidx_d;
  rc4_pkg::byte_t    si_q, si_d, sj_q, sj_d;
  rc4_pkg::byte_t    data_q, data_d;
  logic              last_q, last_d;
  logic [KCW-1:0]    kcnt_q, kcnt_d;
  logic              key_ready_q, key_ready_d;
  logic              out_valid_q, out_valid_d;
  rc4_pkg::byte_t    ob_q, ob_d, ks_q, ks_d;
  logic              eom_q, eom_d, nk_q, nk_d;
  logic              out_free, in_acc, load;
  rc4_pkg::ram_req_t sreq, kreq;
  rc4_pkg::byte_t    s_rdata, k_rdata;

  rc4_ram u_sbox (
    .clk_i  (clk_i),
    .req_i  (sreq),
    .rdata_o(s_rdata)
  );

  rc4_ram u_key (
    .clk_i  (clk_i),
    .req_i  (kreq),
    .rdata_o(k_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == rc4_pkg::ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    kidx_d      = kidx_q;
    si_d        = si_q;
    sj_d        = sj_q;
    data_d      = data_q;
    last_d      = last_q;
    kcnt_d      = kcnt_q;
    key_ready_d = key_ready_q;
    ob_d        = ob_q;
    ks_d        = ks_q;
    eom_d       = eom_q;
    nk_d        = nk_q;
    load        = 1'b0;
    sreq        = '0;
    kreq        = '0;
    unique case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == rc4_pkg::KIND_KEY) begin
            if (kcnt_q < KCW'(KEY_MAX)) begin
              kreq.we    = 1'b1;
              kreq.waddr = 8'(kcnt_q);
              kreq.wdata = byte_in_i;
              kcnt_d     = kcnt_q + KCW'(1);
            end
            if (last_of_run_i) begin
              i_d     = '0;
              state_d = rc4_pkg::ST_INIT;
            end
          end else if (!key_ready_q) begin
            load  = 1'b1;
            ob_d  = byte_in_i;
            ks_d  = '0;
            eom_d = last_of_run_i;
            nk_d  = 1'b1;
          end else begin
            i_d     = i_q + 8'd1;
            data_d  = byte_in_i;
            last_d  = last_of_run_i;
            state_d = rc4_pkg::ST_GS_RI;
          end
        end
      end
      rc4_pkg::ST_INIT: begin
        sreq.we    = 1'b1;
        sreq.waddr = i_q;
        sreq.wdata = i_q;
        if (i_q == 8'hFF) begin
          i_d     = '0;
          j_d     = '0;
          kidx_d  = '0;
          state_d = rc4_pkg::ST_KS_RI;
        end else begin
          i_d = i_q + 8'd1;
        end
      end
      rc4_pkg::ST_KS_RI: begin
        sreq.re    = 1'b1;
        sreq.raddr = i_q;
        kreq.re    = 1'b1;
        kreq.raddr = kidx_q;
        state_d    = rc4_pkg::ST_KS_RJ;
      end
      rc4_pkg::ST_KS_RJ: begin
        si_d       = s_rdata;
        j_d        = j_q + s_rdata + k_rdata;
        sreq.re    = 1'b1;
        sreq.raddr = j_d;
        if ((9'(kidx_q) + 9'd1) == 9'(kcnt_q)) begin
          kidx_d = '0;
        end else begin
          kidx_d = kidx_q + 8'd1;
        end
        state_d = rc4_pkg::ST_KS_WI;
      end
      rc4_pkg::ST_KS_WI: begin
        sreq.we    = 1'b1;
        sreq.waddr = i_q;
        sreq.wdata = s_rdata;
        state_d    = rc4_pkg::ST_KS_WJ;
      end
      rc4_pkg::ST_KS_WJ: begin
        sreq.we    = 1'b1;
        sreq.waddr = j_q;
        sreq.wdata = si_q;
        if (i_q == 8'hFF) begin
          i_d         = '0;
          j_d         = '0;
          kcnt_d      = '0;
          key_ready_d = 1'b1;
          state_d     = rc4_pkg::ST_IDLE;
        end else begin
          i_d     = i_q + 8'd1;
          state_d = rc4_pkg::ST_KS_RI;
        end
      end
      rc4_pkg::ST_GS_RI: begin
        sreq.re    = 1'b1;
        sreq.raddr = i_q;
        state_d    = rc4_pkg::ST_GS_RJ;
      end
      rc4_pkg::ST_GS_RJ: begin
        si_d       = s_rdata;
        j_d        = j_q + s_rdata;
        sreq.re    = 1'b1;
        sreq.raddr = j_d;
        state_d    = rc4_pkg::ST_GS_WI;
      end
      rc4_pkg::ST_GS_WI: begin
        sreq.we    = 1'b1;
        sreq.waddr = i_q;
        sreq.wdata = s_rdata;
        sj_d       = s_rdata;
        state_d    = rc4_pkg::ST_GS_WJ;
      end
      rc4_pkg::ST_GS_WJ: begin
        sreq.we    = 1'b1;
        sreq.waddr = j_q;
        sreq.wdata = si_q;
        state_d    = rc4_pkg::ST_GS_RT;
      end
      rc4_pkg::ST_GS_RT: begin
        sreq.re    = 1'b1;
        sreq.raddr = si_q + sj_q;
        state_d    = rc4_pkg::ST_GS_OUT;
      end
      rc4_pkg::ST_GS_OUT: begin
        if (out_free) begin
          load    = 1'b1;
          ob_d    = data_q ^ s_rdata;
          ks_d    = s_rdata;
          eom_d   = last_q;
          nk_d    = 1'b0;
          state_d = rc4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rc4_pkg::ST_IDLE;
      end
    endcase
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rc4_pkg::ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      kcnt_q      <= '0;
      key_ready_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      kcnt_q      <= kcnt_d;
      key_ready_q <= key_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kidx_q <= kidx_d;
    si_q   <= si_d;
    sj_q   <= sj_d;
    data_q <= data_d;
    last_q <= last_d;
    ob_q   <= ob_d;
    ks_q   <= ks_d;
    eom_q  <= eom_d;
    nk_q   <= nk_d;
  end

  assign out_valid_o      = out_valid_q;
  assign byte_out_o       = ob_q;
  assign keystream_byte_o = ks_q;
  assign end_of_message_o = eom_q;
  assign no_key_o         = nk_q;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the RC4 stream cipher unit.
`timescale 1ns / 100ps

module tb;

  localparam int KEY_MAX = 256;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_OFF_CYCLES = 600;

  typedef struct packed {
    rc4_pkg::byte_t text;
    rc4_pkg::byte_t ks;
    logic           eom;
    logic           nokey;
  } cipher_out_t;

  class rc4_shadow;
    rc4_pkg::byte_t sbox[256];
    rc4_pkg::byte_t key_mem[256];
    int unsigned    key_len;
    rc4_pkg::byte_t idx_i;
    rc4_pkg::byte_t idx_j;
    bit             keyed;
    cipher_out_t    pending_bytes[$];
    int             errors;
    int             seen;

    function new();
      key_len = 0;
      idx_i = 8'h00;
      idx_j = 8'h00;
      keyed = 1'b0;
      errors = 0;
      seen = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function void run_key_schedule();
      int unsigned    len;
      rc4_pkg::byte_t j;
      rc4_pkg::byte_t t;
      len = (key_len == 0) ? 1 : key_len;
      j = 8'h00;
      for (int n = 0; n < 256; n++) sbox[n] = rc4_pkg::byte_t'(n);
      for (int n = 0; n < 256; n++) begin
        j = j + sbox[n] + key_mem[n % len];
        t = sbox[n];
        sbox[n] = sbox[j];
        sbox[j] = t;
      end
      idx_i = 8'h00;
      idx_j = 8'h00;
      key_len = 0;
      keyed = 1'b1;
    endfunction

    function rc4_pkg::byte_t next_keystream_byte();
      rc4_pkg::byte_t t;
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + sbox[idx_i];
      t = sbox[idx_i];
      sbox[idx_i] = sbox[idx_j];
      sbox[idx_j] = t;
      t = sbox[idx_i] + sbox[idx_j];
      return sbox[t];
    endfunction

    function void take_input(logic kind, rc4_pkg::byte_t b, logic last);
      rc4_pkg::byte_t ks;
      if (kind == rc4_pkg::KIND_KEY) begin
        if (key_len < KEY_MAX) begin
          key_mem[key_len] = b;
          key_len++;
        end
        if (last) run_key_schedule();
      end else if (!keyed) begin
        pending_bytes.push_back(cipher_out_t'{b, 8'h00, last, 1'b1});
      end else begin
        ks = next_keystream_byte();
        pending_bytes.push_back(cipher_out_t'{b ^ ks, ks, last, 1'b0});
      end
    endfunction

    task check_output(rc4_pkg::byte_t text, rc4_pkg::byte_t ks, logic eom, logic nokey);
      cipher_out_t want;
      seen++;
      if (pending_bytes.size() == 0) begin
        report($sformatf("result with nothing expected, byte_out=%02h", text));
        return;
      end
      want = pending_bytes.pop_front();
      if (text !== want.text)
        report($sformatf("byte_out %02h, expected %02h", text, want.text));
      if (ks !== want.ks)
        report($sformatf("keystream_byte %02h, expected %02h", ks, want.ks));
      if (eom !== want.eom)
        report($sformatf("end_of_message %b, expected %b", eom, want.eom));
      if (nokey !== want.nokey)
        report($sformatf("no_key %b, expected %b", nokey, want.nokey));
    endtask

    function int outstanding();
      return pending_bytes.size();
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  logic           kind_i = rc4_pkg::KIND_KEY;
  rc4_pkg::byte_t byte_in_i = 8'h00;
  logic           last_of_run_i = 1'b0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  rc4_pkg::byte_t byte_out_o;
  rc4_pkg::byte_t keystream_byte_o;
  logic           end_of_message_o;
  logic           no_key_o;

  rc4_shadow sb = new();
  bit        quiet_in = 1'b0;
  bit        quiet_out = 1'b0;
  bit        hold_off_done = 1'b0;
  int        items_sent = 0;
  int        cycles = 0;

  rc4_stream_cipher_unit #(
    .KEY_MAX(KEY_MAX)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .byte_in_i       (byte_in_i),
    .last_of_run_i   (last_of_run_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_out_o      (byte_out_o),
    .keystream_byte_o(keystream_byte_o),
    .end_of_message_o(end_of_message_o),
    .no_key_o        (no_key_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_input(kind_i, byte_in_i, last_of_run_i);
      if (out_valid_o && !out_stall_i)
        sb.check_output(byte_out_o, keystream_byte_o, end_of_message_o, no_key_o);
    end
  end

  // Each call starts at a rising edge and returns at the edge of its transfer.
  task automatic send_item(input logic kind, input rc4_pkg::byte_t b, input logic last);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    byte_in_i <= b;
    last_of_run_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_key(input int len);
    for (int n = 0; n < len; n++)
      send_item(rc4_pkg::KIND_KEY, rc4_pkg::byte_t'($urandom_range(0, 255)), n == len - 1);
    if (len > KEY_MAX) items_sent -= len - KEY_MAX;
  endtask

  task automatic send_message(input int len);
    for (int n = 0; n < len; n++)
      send_item(rc4_pkg::KIND_DATA, rc4_pkg::byte_t'($urandom_range(0, 255)), n == len - 1);
  endtask

  // Receiver: a random hold-off before each transfer, and once a long one so that the
  // unit backs up and stalls its input.
  initial begin
    int n;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if ($urandom_range(0, 19) == 0) quiet_out = !quiet_out;
      n = quiet_out ? 0 : $urandom_range(0, 12);
      if (!hold_off_done && sb.seen >= 200) begin
        n = HOLD_OFF_CYCLES;
        hold_off_done = 1'b1;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("rc4_stream_cipher_unit regression: fail");
    $finish;
  end

  initial begin
    int  pick;
    bit  first_key;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Data before any key passes through unchanged.
    send_item(rc4_pkg::KIND_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::KIND_DATA, 8'hFF, 1'b1);
    send_item(rc4_pkg::KIND_DATA, 8'hA5, 1'b0);
    send_item(rc4_pkg::KIND_DATA, 8'h5A, 1'b1);
    // A one-byte key of zero.
    send_item(rc4_pkg::KIND_KEY, 8'h00, 1'b1);
    send_item(rc4_pkg::KIND_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::KIND_DATA, 8'hFF, 1'b1);
    send_item(rc4_pkg::KIND_DATA, 8'h55, 1'b0);
    send_item(rc4_pkg::KIND_DATA, 8'hAA, 1'b1);
    // A new key is loaded while keyed; data keeps the old schedule until its last byte.
    send_item(rc4_pkg::KIND_KEY, 8'hFF, 1'b0);
    send_item(rc4_pkg::KIND_KEY, 8'h80, 1'b0);
    send_item(rc4_pkg::KIND_DATA, 8'h3C, 1'b1);
    send_item(rc4_pkg::KIND_KEY, 8'h01, 1'b1);
    send_item(rc4_pkg::KIND_DATA, 8'hC3, 1'b0);
    send_item(rc4_pkg::KIND_DATA, 8'hFF, 1'b1);

    items_sent = 0;
    first_key = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      quiet_in = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (first_key || pick < 8) begin
        // The first random key fills the store and may run past it, so excess bytes are dropped.
        if (first_key || $urandom_range(0, 7) == 0)
          send_key($urandom_range(KEY_MAX, KEY_MAX + 6));
        else
          send_key($urandom_range(1, 16));
        first_key = 1'b0;
      end else if (pick < 12) begin
        repeat ($urandom_range(1, 5))
          send_item(rc4_pkg::KIND_KEY, rc4_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 4))
          send_item(logic'($urandom_range(0, 1)), rc4_pkg::byte_t'($urandom_range(0, 255)),
                    logic'($urandom_range(0, 3) == 0));
      end else begin
        send_message($urandom_range(1, 20));
      end
    end
    send_message(4);
    in_valid_i <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0)
      $display("rc4_stream_cipher_unit regression: pass");
    else
      $display("rc4_stream_cipher_unit regression: fail");
    $finish;
  end

endmodule
